FILE: rtl/core/sha256_pkg.sv
// shared types, constants and round functions for the sha-256 engine
package sha256_pkg;

  localparam int unsigned Rounds     = 64;
  localparam logic [7:0]  PadByte    = 8'h80;
  localparam logic [5:0]  LenStart   = 6'd56;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_EMIT
  } state_e;

  // controller to datapath commands
  typedef struct packed {
    logic       load_byte;
    logic [7:0] byte_val;
    logic       count_inc;
    logic       round_start;
    logic       round_step;
    logic       chain_add;
    logic       reinit;
    logic       latch_len;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [5:0] fill;
    logic [5:0] round_idx;
    logic [7:0] len_byte;
  } status_t;

  localparam logic [31:0] InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_s0(input logic [31:0] x);
    big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] x);
    big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_s0(input logic [31:0] x);
    small_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_s1(input logic [31:0] x);
    small_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

FILE: rtl/core/sha256_datapath.sv
// sha-256 datapath: message schedule window, working vars, chain words
module sha256_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sha256_pkg::cmd_t    cmd_i,
  output sha256_pkg::status_t status_o,
  output logic [255:0]       chain_o
);

  logic [31:0] w_q [16];
  logic [31:0] v_q [8];
  logic [31:0] h_q [8];
  logic [63:0] cnt_q;
  logic [63:0] len_q;
  logic [5:0]  rnd_q;

  logic [31:0] w_new;
  logic [31:0] w_cur;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [5:0]  fill;

  assign fill = cnt_q[5:0];

  // next schedule word from the rolling window (w_q[0] is oldest)
  assign w_new = sha256_pkg::small_s1(w_q[14]) + w_q[9]
               + sha256_pkg::small_s0(w_q[1]) + w_q[0];
  assign w_cur = (rnd_q < 6'd16) ? w_q[rnd_q[3:0]] : w_new;

  // round function
  assign t1 = v_q[7] + sha256_pkg::big_s1(v_q[4])
            + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
            + sha256_pkg::RoundK[rnd_q] + w_cur;
  assign t2 = sha256_pkg::big_s0(v_q[0])
            + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

  // bytes are packed big-endian straight into the message window
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_byte) begin
      w_q[fill[5:2]][{~fill[1:0], 3'b000} +: 8] <= cmd_i.byte_val;
    end
    if (cmd_i.round_start) begin
      for (int i = 0; i < 8; i++) begin
        v_q[i] <= h_q[i];
      end
    end else if (cmd_i.round_step) begin
      if (rnd_q >= 6'd16) begin
        for (int i = 0; i < 15; i++) begin
          w_q[i] <= w_q[i+1];
        end
        w_q[15] <= w_new;
      end
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
    if (cmd_i.latch_len) begin
      len_q <= {cnt_q[60:0], 3'b000};
    end
  end

  // control state: counters and chain words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rnd_q <= '0;
      for (int i = 0; i < 8; i++) begin
        h_q[i] <= sha256_pkg::InitH[i];
      end
    end else begin
      if (cmd_i.count_inc) begin
        cnt_q <= cnt_q + 64'd1;
      end
      if (cmd_i.round_start) begin
        rnd_q <= '0;
      end else if (cmd_i.round_step) begin
        rnd_q <= rnd_q + 6'd1;
      end
      if (cmd_i.chain_add) begin
        for (int i = 0; i < 8; i++) begin
          h_q[i] <= h_q[i] + v_q[i];
        end
      end
      if (cmd_i.reinit) begin
        cnt_q <= '0;
        for (int i = 0; i < 8; i++) begin
          h_q[i] <= sha256_pkg::InitH[i];
        end
      end
    end
  end

  // status back to controller
  always_comb begin
    status_o.fill      = fill;
    status_o.round_idx = rnd_q;
    status_o.len_byte  = len_q[63 - 8*fill[2:0] -: 8];
  end

  for (genvar g = 0; g < 8; g++) begin : g_chain
    assign chain_o[255 - 32*g -: 32] = h_q[g];
  end

endmodule

FILE: rtl/core/sha256_ctrl.sv
// sha-256 controller: request intake, padding, round sequencing, digest output
module sha256_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  input  logic               byte_present_i,
  input  logic               end_of_message_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         word_index_o,
  output logic               last_word_o,
  output sha256_pkg::cmd_t    cmd_o,
  input  sha256_pkg::status_t status_i
);

  sha256_pkg::state_e state_q, state_d;
  logic       pad_q, pad_d;     // 0x80 byte still to be written
  logic       padfirst_q, padfirst_d;
  logic       fin_q, fin_d;     // request carried end of message
  logic       lenph_q, lenph_d; // length bytes being written in this block
  logic [2:0] idx_q, idx_d;
  logic       acc;

  assign acc = in_valid_i && !in_stall_o;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= sha256_pkg::ST_IDLE;
      pad_q      <= 1'b0;
      padfirst_q <= 1'b0;
      fin_q      <= 1'b0;
      lenph_q    <= 1'b0;
      idx_q      <= '0;
    end else begin
      state_q    <= state_d;
      pad_q      <= pad_d;
      padfirst_q <= padfirst_d;
      fin_q      <= fin_d;
      lenph_q    <= lenph_d;
      idx_q      <= idx_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    pad_d      = pad_q;
    padfirst_d = padfirst_q;
    fin_d      = fin_q;
    lenph_d    = lenph_q;
    idx_d      = idx_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      sha256_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (acc) begin
          if (byte_present_i) begin
            cmd_o.load_byte = 1'b1;
            cmd_o.byte_val  = data_byte_i;
            cmd_o.count_inc = 1'b1;
          end
          if (end_of_message_i) begin
            fin_d      = 1'b1;
            pad_d      = 1'b1;
            padfirst_d = 1'b1;
          end
          if (byte_present_i && status_i.fill == 6'd63) begin
            cmd_o.round_start = 1'b1;
            state_d = sha256_pkg::ST_ROUND;
          end else if (end_of_message_i) begin
            // no block due: go straight to padding
            state_d = sha256_pkg::ST_PAD;
          end
        end
      end
      sha256_pkg::ST_PAD: begin
        // one padding byte per cycle, bit length captured first
        if (padfirst_q) begin
          cmd_o.latch_len = 1'b1;
          padfirst_d      = 1'b0;
        end else begin
          cmd_o.load_byte = 1'b1;
          cmd_o.count_inc = 1'b1;
          if (pad_q) begin
            cmd_o.byte_val = sha256_pkg::PadByte;
            pad_d = 1'b0;
          end else if (lenph_q || status_i.fill == sha256_pkg::LenStart) begin
            cmd_o.byte_val = status_i.len_byte;
            lenph_d = 1'b1;
          end else begin
            cmd_o.byte_val = 8'h00;
          end
          if (status_i.fill == 6'd63) begin
            cmd_o.round_start = 1'b1;
            state_d = sha256_pkg::ST_ROUND;
          end
        end
      end
      sha256_pkg::ST_ROUND: begin
        cmd_o.round_step = 1'b1;
        if (status_i.round_idx == 6'(sha256_pkg::Rounds - 1)) begin
          state_d = sha256_pkg::ST_ADD;
        end
      end
      sha256_pkg::ST_ADD: begin
        cmd_o.chain_add = 1'b1;
        // finished once the block holding the length went through
        if (!fin_q) begin
          state_d = sha256_pkg::ST_IDLE;
        end else if (lenph_q) begin
          idx_d   = '0;
          state_d = sha256_pkg::ST_EMIT;
        end else begin
          state_d = sha256_pkg::ST_PAD;
        end
      end
      sha256_pkg::ST_EMIT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            cmd_o.reinit = 1'b1;
            fin_d   = 1'b0;
            lenph_d = 1'b0;
            state_d = sha256_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = sha256_pkg::ST_IDLE;
    endcase
  end

  assign word_index_o = idx_q;
  assign last_word_o  = (idx_q == 3'd7);

  // assertions
  a_emit_idle_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken during digest output");
  a_round_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sha256_pkg::ST_ROUND) |=> (status_i.round_idx != 6'd0) ||
    (state_q == sha256_pkg::ST_ADD)) else $error("round counter out of step");
  a_emit_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> fin_q) else $error("digest without end of message");

endmodule

FILE: rtl/core/sha256_hash_engine_top.sv
// top level of the sha-256 hash engine
// Takes one request per byte (or a bare end marker) and returns the eight
// digest words, index 0 first, after the end-of-message request. Bytes that
// do not complete a block are taken at one per cycle; a byte that completes a
// block stalls input while the single round unit runs the 64 rounds and the
// chain add follows. Closing a message captures the bit length, writes one
// padding byte per cycle and runs each padded block, then returns one digest
// word per cycle while the output is not stalled.
module sha256_hash_engine_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  sha256_pkg::cmd_t    cmd;
  sha256_pkg::status_t status;
  logic [255:0]       chain;

  sha256_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .data_byte_i, .byte_present_i,
    .end_of_message_i, .out_valid_o, .out_stall_i, .word_index_o, .last_word_o,
    .cmd_o(cmd), .status_i(status)
  );

  sha256_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .status_o(status), .chain_o(chain)
  );

  // select the word being returned
  assign digest_word_o = chain[255 - 32*word_index_o -: 32];

endmodule
